[rtl/tcw_pkg.sv]
// Package for the text console cursor writer.
// Holds shared widths, character codes, command codes and the result structure.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int ColumnsDef = 80;
  localparam int RowsDef    = 25;

  localparam int AddrW = 11;
  localparam int CharW = 8;
  localparam int AttrW = 8;
  localparam int CellW = AttrW + CharW;

  localparam logic [AttrW-1:0] AttrReset = 8'd15;

  localparam logic [CharW-1:0] ChNewline   = 8'd10;
  localparam logic [CharW-1:0] ChReturn    = 8'd13;
  localparam logic [CharW-1:0] ChBackspace = 8'd8;
  localparam logic [CharW-1:0] ChBlank     = 8'd32;

  typedef enum logic {
    CMD_PUT   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    cmd_e             command;
  } tcw_item_t;

  typedef struct packed {
    logic             write_enable;
    logic [AddrW-1:0] cell_address;
    logic [CellW-1:0] cell_value;
    logic             scroll_up;
    logic             clear_all;
    logic [AddrW-1:0] cursor_position;
  } tcw_result_t;

endpackage

[rtl/tcw_in_reg.sv]
// Input register of the text console cursor writer.
// Holds one accepted character transaction until the cursor step consumes it.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_in_reg import tcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  tcw_item_t item_i,
  output logic      valid_o,
  input  logic      take_i,
  output tcw_item_t item_o
);

  logic      valid_q;
  logic      valid_d;
  tcw_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/tcw_cursor_step.sv]
// Combinational cursor step of the text console cursor writer.
// Decodes one character or clear command against the current cursor and
// produces the frame store result and the next cursor. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_cursor_step import tcw_pkg::*; #(
  parameter int Columns = ColumnsDef,
  parameter int Rows    = RowsDef,
  localparam int ColW   = (Columns > 1) ? $clog2(Columns) : 1,
  localparam int RowW   = (Rows > 1) ? $clog2(Rows) : 1
) (
  input  tcw_item_t        item_i,
  input  logic [AttrW-1:0] attr_i,
  input  logic [RowW-1:0]  row_i,
  input  logic [ColW-1:0]  col_i,
  output logic [RowW-1:0]  row_o,
  output logic [ColW-1:0]  col_o,
  output tcw_result_t      result_o
);

  localparam int MulW = (RowW + 9 > AddrW) ? RowW + 9 : AddrW;
  localparam logic [ColW-1:0] ColLast = ColW'(Columns - 1);
  localparam logic [RowW-1:0] RowLast = RowW'(Rows - 1);

  logic [RowW-1:0] row_n;
  logic [ColW-1:0] col_n;
  logic [RowW-1:0] wr_row;
  logic [ColW-1:0] wr_col;
  logic            row_step;
  logic            scroll;
  logic            we;
  logic [CharW-1:0] wr_char;
  logic [MulW-1:0] wr_idx;
  logic [MulW-1:0] cur_idx;

  always_comb begin
    row_n    = row_i;
    col_n    = col_i;
    wr_row   = row_i;
    wr_col   = col_i;
    row_step = 1'b0;
    we       = 1'b0;
    wr_char  = item_i.char_code;
    if (item_i.command == CMD_CLEAR) begin
      row_n = '0;
      col_n = '0;
    end else if (item_i.char_code == ChNewline) begin
      col_n    = '0;
      row_step = 1'b1;
    end else if (item_i.char_code == ChReturn) begin
      col_n = '0;
    end else if (item_i.char_code == ChBackspace) begin
      wr_char = ChBlank;
      if (col_i != '0) begin
        col_n = col_i - 1'b1;
        we    = 1'b1;
      end else if (row_i != '0) begin
        row_n = row_i - 1'b1;
        col_n = ColLast;
        we    = 1'b1;
      end
      wr_row = row_n;
      wr_col = col_n;
    end else begin
      we = 1'b1;
      if (col_i == ColLast) begin
        col_n    = '0;
        row_step = 1'b1;
      end else begin
        col_n = col_i + 1'b1;
      end
    end
    scroll = 1'b0;
    if (row_step) begin
      if (row_i == RowLast) begin
        scroll = 1'b1;
        row_n  = RowLast;
        col_n  = '0;
      end else begin
        row_n = row_i + 1'b1;
      end
    end
  end

  assign wr_idx  = MulW'(wr_row) * MulW'(Columns) + MulW'(wr_col);
  assign cur_idx = MulW'(row_n) * MulW'(Columns) + MulW'(col_n);

  always_comb begin
    result_o.write_enable    = we;
    result_o.cell_address    = we ? wr_idx[AddrW-1:0] : '0;
    result_o.cell_value      = we ? {attr_i, wr_char} : '0;
    result_o.scroll_up       = scroll;
    result_o.clear_all       = (item_i.command == CMD_CLEAR);
    result_o.cursor_position = cur_idx[AddrW-1:0];
  end

  assign row_o = row_n;
  assign col_o = col_n;

endmodule

[rtl/tcw_out_reg.sv]
// Result register of the text console cursor writer.
// Holds one finished result transaction until the receiver takes it.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_out_reg import tcw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  tcw_result_t result_i,
  output logic        valid_o,
  input  logic        ready_i,
  output tcw_result_t result_o
);

  logic        valid_q;
  logic        valid_d;
  tcw_result_t result_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

[rtl/text_console_cursor_writer_unit.sv]
// Text console cursor writer, top level.
// The block takes one character or clear command per input transaction and
// returns one frame store result per transaction: an optional cell write, the
// scroll and clear requests, and the new hardware cursor index.
// Input, output and configuration channels all use valid and ready. The
// configuration channel writes the attribute byte and is always ready. The
// user must write it only while no input transaction is in flight; the block
// itself does not enforce this. An accepted input waits in the input register,
// passes the cursor step, which also updates the cursor, and is stored in the
// result register, which offers it. The block takes one transaction per cycle
// while the receiver does not stall, set by the single cursor step.
// Reset homes the cursor to row 0, column 0, sets the attribute to 15 and
// empties both registers. When the receiver stalls, the result register holds
// its transaction, the input register fills behind it, and then in_ready_o
// drops until the receiver takes the result.
// Depends on tcw_pkg, tcw_in_reg, tcw_cursor_step and tcw_out_reg.
`timescale 1ns / 1ps

module text_console_cursor_writer_unit import tcw_pkg::*; #(
  parameter int Columns = ColumnsDef,
  parameter int Rows    = RowsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AttrW-1:0] cfg_text_attribute_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [CharW-1:0] char_code_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             write_enable_o,
  output logic [AddrW-1:0] cell_address_o,
  output logic [CellW-1:0] cell_value_o,
  output logic             scroll_up_o,
  output logic             clear_all_o,
  output logic [AddrW-1:0] cursor_position_o
);

  localparam int ColW = (Columns > 1) ? $clog2(Columns) : 1;
  localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

  logic [AttrW-1:0] attr_q;
  logic [RowW-1:0]  row_q;
  logic [RowW-1:0]  row_d;
  logic [ColW-1:0]  col_q;
  logic [ColW-1:0]  col_d;
  tcw_item_t        in_item;
  tcw_item_t        s1_item;
  logic             s1_valid;
  logic             res_ready;
  logic             s1_take;
  tcw_result_t      step_result;
  tcw_result_t      out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= AttrReset;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_text_attribute_i;
      end
      if (s1_take) begin
        row_q <= row_d;
        col_q <= col_d;
      end
    end
  end

  assign in_item.command   = cmd_e'(command_i);
  assign in_item.char_code = char_code_i;
  assign s1_take           = s1_valid && res_ready;

  tcw_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (s1_valid),
    .take_i  (res_ready),
    .item_o  (s1_item)
  );

  tcw_cursor_step #(
    .Columns (Columns),
    .Rows    (Rows)
  ) u_cursor_step (
    .item_i   (s1_item),
    .attr_i   (attr_q),
    .row_i    (row_q),
    .col_i    (col_q),
    .row_o    (row_d),
    .col_o    (col_d),
    .result_o (step_result)
  );

  tcw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid),
    .ready_o  (res_ready),
    .result_i (step_result),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign write_enable_o    = out_result.write_enable;
  assign cell_address_o    = out_result.cell_address;
  assign cell_value_o      = out_result.cell_value;
  assign scroll_up_o       = out_result.scroll_up;
  assign clear_all_o       = out_result.clear_all;
  assign cursor_position_o = out_result.cursor_position;

endmodule

[bench/console_result_check.sv]
// Result checker for the text console cursor writer testbench.
// Watches the configuration, input and output channels, predicts each result and compares it.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module console_result_check import tcw_pkg::*; #(
  parameter int Columns = ColumnsDef,
  parameter int Rows    = RowsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [AttrW-1:0] cfg_text_attribute_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             command_i,
  input  logic [CharW-1:0] char_code_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic             write_enable_i,
  input  logic [AddrW-1:0] cell_address_i,
  input  logic [CellW-1:0] cell_value_i,
  input  logic             scroll_up_i,
  input  logic             clear_all_i,
  input  logic [AddrW-1:0] cursor_position_i,
  output int               pending_o,
  output int               fails_o,
  output int               results_o,
  output int               writes_o,
  output int               scrolls_o,
  output int               clears_o
);

  tcw_result_t      expected_results[$];
  logic [AttrW-1:0] attribute;
  int               pred_row;
  int               pred_col;

  function automatic logic [AddrW-1:0] cell_at(int row, int col);
    logic [AddrW-1:0] index;
    index = AddrW'(row * Columns + col);
    return index;
  endfunction

  function automatic tcw_result_t console_step(cmd_e cmd, logic [CharW-1:0] ch);
    tcw_result_t r;
    int row;
    int col;
    r = '0;
    row = pred_row;
    col = pred_col;
    if (cmd == CMD_CLEAR) begin
      r.clear_all = 1'b1;
      row = 0;
      col = 0;
    end else if (ch == ChNewline) begin
      col = 0;
      row++;
    end else if (ch == ChReturn) begin
      col = 0;
    end else if (ch == ChBackspace) begin
      if (col > 0 || row > 0) begin
        if (col > 0) begin
          col--;
        end else begin
          row--;
          col = Columns - 1;
        end
        r.write_enable = 1'b1;
        r.cell_address = cell_at(row, col);
        r.cell_value   = {attribute, ChBlank};
      end
    end else begin
      r.write_enable = 1'b1;
      r.cell_address = cell_at(row, col);
      r.cell_value   = {attribute, ch};
      col++;
      if (col >= Columns) begin
        col = 0;
        row++;
      end
    end
    if (row >= Rows) begin
      r.scroll_up = 1'b1;
      row = Rows - 1;
      col = 0;
    end
    pred_row = row;
    pred_col = col;
    r.cursor_position = cell_at(row, col);
    return r;
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tcw_result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      attribute  = AttrReset;
      pred_row   = 0;
      pred_col   = 0;
      pending_o  = 0;
      fails_o    = 0;
      results_o  = 0;
      writes_o   = 0;
      scrolls_o  = 0;
      clears_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        writes_o  += write_enable_i;
        scrolls_o += scroll_up_i;
        clears_o  += clear_all_i;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected, cursor_position %0d",
                 cursor_position_i);
          fails_o++;
        end else begin
          want = expected_results.pop_front();
          compare_field("write_enable", want.write_enable, write_enable_i);
          compare_field("cell_address", want.cell_address, cell_address_i);
          compare_field("cell_value", want.cell_value, cell_value_i);
          compare_field("scroll_up", want.scroll_up, scroll_up_i);
          compare_field("clear_all", want.clear_all, clear_all_i);
          compare_field("cursor_position", want.cursor_position, cursor_position_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        attribute = cfg_text_attribute_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(console_step(cmd_e'(command_i), char_code_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

[bench/testbench.sv]
// Top of the text console cursor writer testbench: clock, reset, stimulus and verdict.
// Drives directed and random streams, with random stalls outside the quiet phases.
// Depends on tcw_pkg, text_console_cursor_writer_unit and console_result_check.
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int IdleLimit  = 1000;
  localparam int PhaseItems = 105;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [AttrW-1:0] cfg_attr = '0;
  logic             cfg_ready;
  logic             in_valid = 1'b0;
  logic             in_ready;
  cmd_e             in_cmd = CMD_PUT;
  logic [CharW-1:0] in_char = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             write_enable;
  logic [AddrW-1:0] cell_address;
  logic [CellW-1:0] cell_value;
  logic             scroll_up;
  logic             clear_all;
  logic [AddrW-1:0] cursor_position;

  int pending;
  int fails;
  int results;
  int writes;
  int scrolls;
  int clears;
  int items_sent = 0;
  int attr_writes = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  text_console_cursor_writer_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_text_attribute_i(cfg_attr),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .command_i           (in_cmd),
    .char_code_i         (in_char),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .write_enable_o      (write_enable),
    .cell_address_o      (cell_address),
    .cell_value_o        (cell_value),
    .scroll_up_o         (scroll_up),
    .clear_all_o         (clear_all),
    .cursor_position_o   (cursor_position)
  );

  console_result_check result_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_text_attribute_i(cfg_attr),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .command_i           (in_cmd),
    .char_code_i         (in_char),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .write_enable_i      (write_enable),
    .cell_address_i      (cell_address),
    .cell_value_i        (cell_value),
    .scroll_up_i         (scroll_up),
    .clear_all_i         (clear_all),
    .cursor_position_i   (cursor_position),
    .pending_o           (pending),
    .fails_o             (fails),
    .results_o           (results),
    .writes_o            (writes),
    .scrolls_o           (scrolls),
    .clears_o            (clears)
  );

  function automatic int draw_wait();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  task automatic put_item(cmd_e cmd, logic [CharW-1:0] ch);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_char  <= ch;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_attribute(logic [AttrW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_attr  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    attr_writes++;
  endtask

  task automatic random_phase(int count);
    int sent;
    int kind;
    int len;
    logic [CharW-1:0] ch;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        len = $urandom_range(1, 90);
        repeat (len) begin
          ch = CharW'($urandom_range(0, 255));
          if (ch == ChNewline || ch == ChReturn || ch == ChBackspace) ch = ChBlank;
          put_item(CMD_PUT, ch);
        end
      end else if (kind < 12) begin
        len = $urandom_range(1, 30);
        repeat (len) put_item(CMD_PUT, ChNewline);
      end else if (kind < 15) begin
        len = $urandom_range(1, 90);
        repeat (len) put_item(CMD_PUT, ChBackspace);
      end else if (kind < 17) begin
        len = 1;
        put_item(CMD_PUT, ChReturn);
      end else if (kind == 17) begin
        len = 1;
        put_item(CMD_CLEAR, CharW'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          put_item(($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_PUT,
                   CharW'($urandom_range(0, 255)));
        end
      end
      sent += len;
    end
  endtask

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [AttrW-1:0] phase_attr [6];
    logic [AttrW-1:0] attr;
    phase_attr = '{8'h00, 8'hFF, 8'h5A, 8'h80, 8'hA5, 8'h01};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // The cursor starts at the top-left corner, so the first backspace is a no-op.
    put_item(CMD_PUT, ChBackspace);
    put_item(CMD_PUT, 8'h41);
    put_item(CMD_PUT, 8'h00);
    put_item(CMD_PUT, 8'hFF);
    put_item(CMD_PUT, 8'h80);
    put_item(CMD_PUT, 8'h7F);
    put_item(CMD_PUT, ChBlank);
    put_item(CMD_PUT, ChBackspace);
    put_item(CMD_PUT, ChReturn);
    put_item(CMD_PUT, ChNewline);
    put_item(CMD_PUT, ChBackspace);
    put_item(CMD_PUT, 8'h5A);
    put_item(CMD_CLEAR, 8'hFF);
    put_item(CMD_CLEAR, ChNewline);
    put_item(CMD_PUT, ChReturn);
    put_item(CMD_PUT, ChNewline);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      attr = phase_attr[p];
      if (p == 2 || p == 4) attr = AttrW'($urandom_range(0, 255));
      write_attribute(attr);
      quiet_phase = (p % 2 == 1);
      random_phase(PhaseItems);
    end

    wait_drained();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d characters and commands over %0d attribute settings.",
             items_sent, attr_writes + 1);
    $display("Checked %0d results: %0d cell writes, %0d scrolls, %0d clears.",
             results, writes, scrolls, clears);
    if (fails == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
